>>> src/pfd_pkg.sv
`timescale 1ns / 1ps
package pfd_pkg;

  // Command codes
  localparam logic [1:0] FUNC_PLOT = 2'd0;
  localparam logic [1:0] FUNC_RECT = 2'd1;
  localparam logic [1:0] FUNC_FILL = 2'd2;
  localparam logic [1:0] FUNC_READ = 2'd3;

  // Pixel color codes (3 sets as well as 1)
  localparam logic [1:0] COLOR_CLEAR  = 2'd0;
  localparam logic [1:0] COLOR_SET    = 2'd1;
  localparam logic [1:0] COLOR_TOGGLE = 2'd2;

  // Rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Signed width for rotated coordinates: covers -255 .. 1023
  localparam int PIX_W = 11;

  // Microcode step addresses
  localparam int UPC_W = 3;
  localparam logic [UPC_W-1:0] U_IDLE    = 3'd0;
  localparam logic [UPC_W-1:0] U_PIX_RD  = 3'd1;
  localparam logic [UPC_W-1:0] U_PIX_WR  = 3'd2;
  localparam logic [UPC_W-1:0] U_FILL    = 3'd3;
  localparam logic [UPC_W-1:0] U_BYTE_RD = 3'd4;
  localparam logic [UPC_W-1:0] U_DONE    = 3'd5;
  localparam logic [UPC_W-1:0] U_CLEAR   = 3'd6;

  // Jump conditions. When the condition is false:
  //   J_WALK goes back one step, J_SWEEP / J_OUT / J_DISPATCH hold.
  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_DISPATCH = 3'd1,
    J_WALK     = 3'd2,
    J_SWEEP    = 3'd3,
    J_OUT      = 3'd4
  } jmp_e;

  typedef struct packed {
    logic             take;     // open the input channel
    logic             rd_pix;   // read byte under the walk pixel, latch address and mask
    logic             rd_byte;  // read byte at the command's read index
    logic             wr_pix;   // write modified byte, advance the walk
    logic             wr_fill;  // write fill byte, advance the sweep address
    logic             emit;     // load the result register
    jmp_e             jmp;
    logic [UPC_W-1:0] target;
  } uop_t;

  typedef struct packed {
    logic walk_end;
    logic sweep_end;
    logic out_free;
  } pfd_stat_t;

  function automatic uop_t ucode_rom(input logic [UPC_W-1:0] upc);
    uop_t w;
    w = '0;
    w.jmp = J_NEXT;
    w.target = U_IDLE;
    case (upc)
      U_IDLE: begin
        w.take = 1'b1;
        w.jmp  = J_DISPATCH;
      end
      U_PIX_RD: begin
        w.rd_pix = 1'b1;
        w.jmp    = J_NEXT;
      end
      U_PIX_WR: begin
        w.wr_pix = 1'b1;
        w.jmp    = J_WALK;
        w.target = U_DONE;
      end
      U_FILL: begin
        w.wr_fill = 1'b1;
        w.jmp     = J_SWEEP;
        w.target  = U_DONE;
      end
      U_BYTE_RD: begin
        w.rd_byte = 1'b1;
        w.jmp     = J_NEXT;
      end
      U_DONE: begin
        w.emit   = 1'b1;
        w.jmp    = J_OUT;
        w.target = U_IDLE;
      end
      U_CLEAR: begin
        w.wr_fill = 1'b1;
        w.jmp     = J_SWEEP;
        w.target  = U_IDLE;
      end
      default: begin
        w.jmp    = J_OUT;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] dispatch(input logic [1:0] func);
    logic [UPC_W-1:0] entry;
    case (func)
      FUNC_PLOT: entry = U_PIX_RD;
      FUNC_RECT: entry = U_PIX_RD;
      FUNC_FILL: entry = U_FILL;
      FUNC_READ: entry = U_BYTE_RD;
      default:   entry = U_IDLE;
    endcase
    return entry;
  endfunction

endpackage

>>> src/page_framebuffer_draw.sv
`timescale 1ns / 1ps
// Steps after accept: plot reads then writes one byte, read fetches one byte, rectangle reads
// and writes each pixel of the corner-bounded box, fill writes all DEPTH store bytes.
// Throughput: one command at a time; the input reopens the cycle after the result loads.
// Each pixel costs a read and a write on the frame store.
// Reset (async, active low) clears rotation and runs a clearing pass over every byte of the
// store with the input stalled; config writes are taken meanwhile.
module page_framebuffer_draw
  import pfd_pkg::*;
#(
  parameter int PANEL_WIDTH  = 72,
  parameter int PANEL_HEIGHT = 40
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration channel: rotation in quarter turns
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_rotation_i,
  // Command channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] x_first_i,
  input  logic [7:0] y_first_i,
  input  logic [7:0] x_second_i,
  input  logic [7:0] y_second_i,
  input  logic [1:0] pixel_color_i,
  input  logic       fill_rect_i,
  input  logic       toggle_rect_i,
  input  logic [8:0] read_index_i,
  // Result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [1:0] func_echo_o
);

  logic [1:0] rotation_q;
  uop_t       uop;
  pfd_stat_t  stat;
  logic       accept;

  // The rotation register takes every config transaction
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= ROT_0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rotation_q <= cfg_rotation_i;
    end
  end

  // Only the idle microcode step opens the command channel
  assign in_stall_o = !uop.take;

  // Microcode sequencer: step counter, control ROM, conditional jumps
  pfd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .stat_i     (stat),
    .uop_o      (uop),
    .accept_o   (accept)
  );

  // Walk counters, rotation and address map, frame store, result register
  pfd_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .uop_i         (uop),
    .accept_i      (accept),
    .rotation_i    (rotation_q),
    .func_i        (func_i),
    .x_first_i     (x_first_i),
    .y_first_i     (y_first_i),
    .x_second_i    (x_second_i),
    .y_second_i    (y_second_i),
    .pixel_color_i (pixel_color_i),
    .fill_rect_i   (fill_rect_i),
    .toggle_rect_i (toggle_rect_i),
    .read_index_i  (read_index_i),
    .out_stall_i   (out_stall_i),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .read_data_o   (read_data_o),
    .func_echo_o   (func_echo_o)
  );

endmodule

>>> src/pfd_seq.sv
`timescale 1ns / 1ps
module pfd_seq
  import pfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] func_i,
  input  pfd_stat_t  stat_i,
  output uop_t       uop_o,
  output logic       accept_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  uop_t             uop;

  assign uop      = ucode_rom(upc_q);
  assign uop_o    = uop;
  assign accept_o = uop.take & in_valid_i;

  always_comb begin
    case (uop.jmp)
      J_NEXT:     upc_d = upc_q + UPC_W'(1);
      J_DISPATCH: upc_d = accept_o ? dispatch(func_i) : upc_q;
      J_WALK:     upc_d = stat_i.walk_end ? uop.target : upc_q - UPC_W'(1);
      J_SWEEP:    upc_d = stat_i.sweep_end ? uop.target : upc_q;
      J_OUT:      upc_d = stat_i.out_free ? uop.target : upc_q;
      default:    upc_d = upc_q;
    endcase
  end

  // Start in the clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> src/pfd_datapath.sv
`timescale 1ns / 1ps
module pfd_datapath
  import pfd_pkg::*;
#(
  parameter int PANEL_WIDTH  = 72,
  parameter int PANEL_HEIGHT = 40
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  uop_t       uop_i,
  input  logic       accept_i,
  input  logic [1:0] rotation_i,
  input  logic [1:0] func_i,
  input  logic [7:0] x_first_i,
  input  logic [7:0] y_first_i,
  input  logic [7:0] x_second_i,
  input  logic [7:0] y_second_i,
  input  logic [1:0] pixel_color_i,
  input  logic       fill_rect_i,
  input  logic       toggle_rect_i,
  input  logic [8:0] read_index_i,
  input  logic       out_stall_i,
  output pfd_stat_t  stat_o,
  output logic       out_valid_o,
  output logic [7:0] read_data_o,
  output logic [1:0] func_echo_o
);

  localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
  localparam int DEPTH      = PANEL_WIDTH * PAGE_COUNT;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = (AW > 9) ? AW : 9;

  // Command registers
  logic [1:0]    func_q;
  logic [1:0]    color_q;
  logic          solid_q;
  logic          fill_ones_q;
  logic [8:0]    rd_idx_q;
  logic          rd_ok_q;
  logic [7:0]    xlo_q, xhi_q, ylo_q, yhi_q, x_q, y_q;
  logic [7:0]    xlo_d, xhi_d, ylo_d, yhi_d;

  // Pixel address path
  logic signed [PIX_W-1:0] xs, ys, px, py;
  logic [PIX_W-1:0]        pxu, pyu, idx_full;
  logic                    hit, edge_px;
  logic [AW-1:0]           pix_addr, pix_addr_q;
  logic [7:0]              mask, mask_q;
  logic                    pix_we_q;

  // Memory
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] raddr, waddr, sweep_q;
  logic [CW-1:0] rd_idx_ext;
  logic          mem_we, mem_re;
  logic [7:0]    wdata, pix_wdata;

  // Result register
  logic          out_valid_q;
  logic [7:0]    read_data_q;
  logic [1:0]    func_echo_q;
  logic          out_free, load_out;

  // Order the rectangle corners; a plot uses the first corner for both
  always_comb begin
    if (func_i == FUNC_RECT) begin
      xlo_d = (x_second_i < x_first_i) ? x_second_i : x_first_i;
      xhi_d = (x_second_i < x_first_i) ? x_first_i : x_second_i;
      ylo_d = (y_second_i < y_first_i) ? y_second_i : y_first_i;
      yhi_d = (y_second_i < y_first_i) ? y_first_i : y_second_i;
    end else begin
      xlo_d = x_first_i;
      xhi_d = x_first_i;
      ylo_d = y_first_i;
      yhi_d = y_first_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      func_q   <= func_i;
      color_q  <= (func_i == FUNC_RECT) ? (toggle_rect_i ? COLOR_TOGGLE : COLOR_SET)
                                        : pixel_color_i;
      solid_q  <= (func_i != FUNC_RECT) | fill_rect_i;
      rd_idx_q <= read_index_i;
      rd_ok_q  <= (CW'(read_index_i) < CW'(DEPTH));
      xlo_q    <= xlo_d;
      xhi_q    <= xhi_d;
      ylo_q    <= ylo_d;
      yhi_q    <= yhi_d;
      x_q      <= xlo_d;
      y_q      <= ylo_d;
    end else if (uop_i.wr_pix) begin
      // Advance the walk row by row
      if (x_q == xhi_q) begin
        x_q <= xlo_q;
        y_q <= y_q + 8'd1;
      end else begin
        x_q <= x_q + 8'd1;
      end
    end
  end

  assign stat_o.walk_end = (x_q == xhi_q) && (y_q == yhi_q);

  // Rotate, then bounds check and map to a page byte
  assign xs = $signed({3'b000, x_q});
  assign ys = $signed({3'b000, y_q});

  always_comb begin
    case (rotation_i)
      ROT_0: begin
        px = xs;
        py = ys;
      end
      ROT_90: begin
        px = ys;
        py = $signed(PIX_W'(PANEL_WIDTH - 1)) - xs;
      end
      ROT_180: begin
        px = $signed(PIX_W'(PANEL_WIDTH - 1)) - xs;
        py = $signed(PIX_W'(PANEL_HEIGHT - 1)) - ys;
      end
      ROT_270: begin
        px = $signed(PIX_W'(PANEL_HEIGHT - 1)) - ys;
        py = xs;
      end
      default: begin
        px = xs;
        py = ys;
      end
    endcase
  end

  assign pxu      = $unsigned(px);
  assign pyu      = $unsigned(py);
  assign hit      = !pxu[PIX_W-1] && (pxu < PIX_W'(PANEL_WIDTH)) &&
                    !pyu[PIX_W-1] && (pyu < PIX_W'(PANEL_HEIGHT));
  assign idx_full = pxu + (pyu >> 3) * PIX_W'(PANEL_WIDTH);
  assign pix_addr = idx_full[AW-1:0];
  assign mask     = 8'd1 << pyu[2:0];
  assign edge_px  = (x_q == xlo_q) || (x_q == xhi_q) || (y_q == ylo_q) || (y_q == yhi_q);

  always_ff @(posedge clk_i) begin
    if (uop_i.rd_pix) begin
      pix_addr_q <= pix_addr;
      mask_q     <= mask;
      pix_we_q   <= hit && (solid_q || edge_px);
    end
  end

  // Sweep address for fill and the clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      fill_ones_q <= 1'b0;
    end else begin
      if (accept_i && (func_i == FUNC_FILL)) begin
        sweep_q     <= '0;
        fill_ones_q <= (pixel_color_i != COLOR_CLEAR);
      end else if (uop_i.wr_fill) begin
        sweep_q <= stat_o.sweep_end ? '0 : sweep_q + AW'(1);
      end
    end
  end

  assign stat_o.sweep_end = (sweep_q == AW'(DEPTH - 1));

  // Read-modify-write of one byte
  always_comb begin
    case (color_q)
      COLOR_CLEAR:  pix_wdata = rdata_q & ~mask_q;
      COLOR_TOGGLE: pix_wdata = rdata_q ^ mask_q;
      default:      pix_wdata = rdata_q | mask_q;
    endcase
  end

  assign rd_idx_ext = CW'(rd_idx_q);
  assign raddr      = uop_i.rd_byte ? rd_idx_ext[AW-1:0] : pix_addr;
  assign mem_re     = uop_i.rd_byte | uop_i.rd_pix;
  assign mem_we     = uop_i.wr_fill | (uop_i.wr_pix & pix_we_q);
  assign waddr      = uop_i.wr_fill ? sweep_q : pix_addr_q;
  assign wdata      = uop_i.wr_fill ? {8{fill_ones_q}} : pix_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Result register, free when empty or draining this cycle
  assign out_free        = !out_valid_q || !out_stall_i;
  assign stat_o.out_free = out_free;
  assign load_out        = uop_i.emit & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      read_data_q <= ((func_q == FUNC_READ) && rd_ok_q) ? rdata_q : 8'd0;
      func_echo_q <= func_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign func_echo_o = func_echo_q;

endmodule

>>> src/pfd_checker.sv
`timescale 1ns / 1ps
module pfd_checker
  import pfd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic [1:0] func_echo_o
);

  // One command in flight: the input closes right after a transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open the cycle after a command transaction");

  // A fresh result comes with the input reopened
  a_result_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result raised while command channel still stalled");

  // Only a read command carries data
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (func_echo_o != FUNC_READ) |-> read_data_o == 8'd0)
    else $error("nonzero read_data on a non-read result");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(read_data_o) && $stable(func_echo_o))
    else $error("stalled result changed");

endmodule

bind page_framebuffer_draw pfd_checker u_pfd_checker (.*);

>>> sim/tb_page_framebuffer_draw.sv
`timescale 1ns / 1ps
module tb_page_framebuffer_draw;
  import pfd_pkg::*;

  localparam int PANEL_WIDTH  = 72;
  localparam int PANEL_HEIGHT = 40;
  localparam int STORE_BYTES  = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
  localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
  localparam int PHASE_ITEMS  = 330;

  // The second color code that sets a pixel
  localparam logic [1:0] COLOR_SET_ALT = 2'd3;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_rotation_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] func_i;
  logic [7:0] x_first_i;
  logic [7:0] y_first_i;
  logic [7:0] x_second_i;
  logic [7:0] y_second_i;
  logic [1:0] pixel_color_i;
  logic       fill_rect_i;
  logic       toggle_rect_i;
  logic [8:0] read_index_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] read_data_o;
  logic [1:0] func_echo_o;

  // Set by the stimulus to ask the receiver for one long hold-off
  bit hold_request = 1'b0;
  // Final phase: no idling on either side
  bit calm = 1'b0;

  typedef struct {
    logic [1:0] func;
    logic [7:0] x_first;
    logic [7:0] y_first;
    logic [7:0] x_second;
    logic [7:0] y_second;
    logic [1:0] pixel_color;
    logic       fill_rect;
    logic       toggle_rect;
    logic [8:0] read_index;
  } draw_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic [1:0] func;
  } frame_result_t;

  // Shadow copy of the frame store and rotation. Each accepted command is
  // applied here and the result it owes is queued in order.
  class frame_shadow;
    logic [7:0]    frame [STORE_BYTES];
    logic [1:0]    rotation;
    frame_result_t owed_results [$];
    int            errors;
    int            checked;
    int            cmd_count [4];
    bit [3:0]      rotations_seen;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      rotation = ROT_0;
      errors = 0;
      checked = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
      rotations_seen = '0;
    endfunction

    function void set_rotation(logic [1:0] rot);
      rotation = rot;
      rotations_seen[rot] = 1'b1;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Rotate, drop if off the panel, then read-modify-write the page byte
    function void plot_pixel(int x, int y, logic [1:0] color);
      int px;
      int py;
      int idx;
      logic [7:0] mask;
      case (rotation)
        ROT_90: begin
          px = y;
          py = PANEL_WIDTH - 1 - x;
        end
        ROT_180: begin
          px = PANEL_WIDTH - 1 - x;
          py = PANEL_HEIGHT - 1 - y;
        end
        ROT_270: begin
          px = PANEL_HEIGHT - 1 - y;
          py = x;
        end
        default: begin
          px = x;
          py = y;
        end
      endcase
      if (px < 0 || px >= PANEL_WIDTH || py < 0 || py >= PANEL_HEIGHT) return;
      idx  = px + (py / 8) * PANEL_WIDTH;
      mask = 8'h01 << (py % 8);
      case (color)
        COLOR_TOGGLE: frame[idx] = frame[idx] ^ mask;
        COLOR_CLEAR:  frame[idx] = frame[idx] & ~mask;
        default:      frame[idx] = frame[idx] | mask;
      endcase
    endfunction

    // Corners sorted, both ends inclusive; 255 is simply the last step
    function void paint_rect(int x0, int y0, int x1, int y1, logic filled, logic toggle);
      int lo_x;
      int hi_x;
      int lo_y;
      int hi_y;
      lo_x = (x1 < x0) ? x1 : x0;
      hi_x = (x1 < x0) ? x0 : x1;
      lo_y = (y1 < y0) ? y1 : y0;
      hi_y = (y1 < y0) ? y0 : y1;
      for (int y = lo_y; y <= hi_y; y++) begin
        for (int x = lo_x; x <= hi_x; x++) begin
          if (filled || x == lo_x || x == hi_x || y == lo_y || y == hi_y)
            plot_pixel(x, y, toggle ? COLOR_TOGGLE : COLOR_SET);
        end
      end
    endfunction

    function void note_command(draw_cmd_t c);
      frame_result_t r;
      r.data = 8'h00;
      r.func = c.func;
      cmd_count[c.func]++;
      case (c.func)
        FUNC_PLOT: plot_pixel(int'(c.x_first), int'(c.y_first), c.pixel_color);
        FUNC_RECT: paint_rect(int'(c.x_first), int'(c.y_first), int'(c.x_second),
                              int'(c.y_second), c.fill_rect, c.toggle_rect);
        FUNC_FILL: foreach (frame[i]) frame[i] = (c.pixel_color != COLOR_CLEAR) ? 8'hff : 8'h00;
        default: begin
          if (c.read_index < STORE_BYTES) r.data = frame[c.read_index];
        end
      endcase
      owed_results.push_back(r);
    endfunction

    function void check_result(logic [7:0] data, logic [1:0] func);
      frame_result_t r;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: read_data %0h func_echo %0d", data, func);
        errors++;
        return;
      end
      r = owed_results.pop_front();
      checked++;
      if (func !== r.func) begin
        $error("func_echo mismatch: expected %0d, got %0d", r.func, func);
        errors++;
      end
      if (data !== r.data) begin
        $error("read_data mismatch: expected %0h, got %0h", r.data, data);
        errors++;
      end
    endfunction
  endclass

  frame_shadow sb = new();

  page_framebuffer_draw #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_rotation_i(cfg_rotation_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .x_first_i     (x_first_i),
    .y_first_i     (y_first_i),
    .x_second_i    (x_second_i),
    .y_second_i    (y_second_i),
    .pixel_color_i (pixel_color_i),
    .fill_rect_i   (fill_rect_i),
    .toggle_rect_i (toggle_rect_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .func_echo_o   (func_echo_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit: far beyond the slowest legal run (clearing pass, large
  // rectangles, fills, every stall burst and the long hold-off)
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: check every transaction taken at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(read_data_o, func_echo_o);
  end

  // Receiver stall: random bursts, one long hold-off on request, none when calm.
  // One assignment per falling edge.
  initial begin
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0 && !calm) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left   = $urandom_range(0, 7);
        out_stall_i <= 1'b1;
      end else begin
        stall_left   = 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic draw_cmd_t make_cmd(logic [1:0] func, int xa, int ya, int xb, int yb,
                                         logic [1:0] color, logic filled, logic toggle,
                                         int idx);
    draw_cmd_t c;
    c.func        = func;
    c.x_first     = 8'(xa);
    c.y_first     = 8'(ya);
    c.x_second    = 8'(xb);
    c.y_second    = 8'(yb);
    c.pixel_color = color;
    c.fill_rect   = filled;
    c.toggle_rect = toggle;
    c.read_index  = 9'(idx);
    return c;
  endfunction

  function automatic int clip_byte(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Random command: every field random, then shaped by the command so that
  // most pixels land on or near the panel and most rectangles stay small
  function automatic draw_cmd_t random_command();
    draw_cmd_t c;
    int pick;
    int span;
    int reach;
    int dx;
    int dy;
    c.func        = FUNC_READ;
    c.x_first     = 8'($urandom);
    c.y_first     = 8'($urandom);
    c.x_second    = 8'($urandom);
    c.y_second    = 8'($urandom);
    c.pixel_color = 2'($urandom);
    c.fill_rect   = 1'($urandom);
    c.toggle_rect = 1'($urandom);
    c.read_index  = 9'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 52) c.func = FUNC_PLOT;
    else if (pick < 68) c.func = FUNC_RECT;
    else if (pick < 70) c.func = FUNC_FILL;
    case (c.func)
      FUNC_PLOT: begin
        if ($urandom_range(0, 7) != 0) begin
          c.x_first = 8'($urandom_range(0, 79));
          c.y_first = 8'($urandom_range(0, 79));
        end
      end
      FUNC_RECT: begin
        span  = ($urandom_range(0, 59) == 0) ? 63 : 7;
        reach = ($urandom_range(0, 9) == 0) ? 255 : 79;
        c.x_first = 8'($urandom_range(0, reach));
        c.y_first = 8'($urandom_range(0, reach));
        dx = $urandom_range(0, span);
        dy = $urandom_range(0, span);
        c.x_second = 8'(clip_byte($urandom_range(0, 1) ? c.x_first + dx : c.x_first - dx));
        c.y_second = 8'(clip_byte($urandom_range(0, 1) ? c.y_first + dy : c.y_first - dy));
      end
      FUNC_READ: begin
        if ($urandom_range(0, 7) == 0) c.read_index = 9'($urandom_range(STORE_BYTES, 511));
        else c.read_index = 9'($urandom_range(0, STORE_BYTES - 1));
      end
      default: ;
    endcase
    return c;
  endfunction

  // Offer one command and hold it until taken, then drop valid; a random
  // gap may follow before the next command.
  task automatic send_command(input draw_cmd_t c);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    func_i        <= c.func;
    x_first_i     <= c.x_first;
    y_first_i     <= c.y_first;
    x_second_i    <= c.x_second;
    y_second_i    <= c.y_second;
    pixel_color_i <= c.pixel_color;
    fill_rect_i   <= c.fill_rect;
    toggle_rect_i <= c.toggle_rect;
    read_index_i  <= c.read_index;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(c);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    if (!calm && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait until every owed result has been taken
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write the rotation register; called after reset and whenever no results are owed
  task automatic write_rotation(input logic [1:0] rot);
    @(negedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_rotation_i <= rot;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_rotation(rot);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [1:0] rot_order [4];
    logic [1:0] rot;
    rot_order[0] = ROT_90;
    rot_order[1] = ROT_180;
    rot_order[2] = ROT_270;
    rot_order[3] = ROT_0;

    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_rotation_i = ROT_0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_PLOT;
    x_first_i      = '0;
    y_first_i      = '0;
    x_second_i     = '0;
    y_second_i     = '0;
    pixel_color_i  = COLOR_CLEAR;
    fill_rect_i    = 1'b0;
    toggle_rect_i  = 1'b0;
    read_index_i   = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The clearing pass after reset keeps the input stalled; the first command
    // handshake waits for it, while the rotation write is taken during it.
    write_rotation(ROT_0);

    // Directed: panel corners, off-panel pixels, every color, swapped and
    // degenerate rectangles, a walk that runs into 255, reads past the store
    send_command(make_cmd(FUNC_FILL, 0, 0, 0, 0, COLOR_CLEAR, 0, 0, 0));
    send_command(make_cmd(FUNC_PLOT, 0, 0, 255, 255, COLOR_SET, 1, 1, 511));
    send_command(make_cmd(FUNC_PLOT, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, COLOR_SET_ALT,
                          0, 0, 0));
    send_command(make_cmd(FUNC_PLOT, PANEL_WIDTH, 0, 0, 0, COLOR_SET, 0, 0, 0));
    send_command(make_cmd(FUNC_PLOT, 0, PANEL_HEIGHT, 0, 0, COLOR_SET, 0, 0, 0));
    send_command(make_cmd(FUNC_PLOT, 255, 255, 0, 0, COLOR_TOGGLE, 0, 0, 0));
    send_command(make_cmd(FUNC_READ, 0, 0, 0, 0, COLOR_CLEAR, 0, 0, 0));
    send_command(make_cmd(FUNC_READ, 0, 0, 0, 0, COLOR_CLEAR, 0, 0, STORE_BYTES - 1));
    send_command(make_cmd(FUNC_PLOT, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, COLOR_TOGGLE,
                          0, 0, 0));
    send_command(make_cmd(FUNC_PLOT, 0, 0, 0, 0, COLOR_CLEAR, 0, 0, 0));
    send_command(make_cmd(FUNC_RECT, 5, 3, 2, 0, COLOR_CLEAR, 0, 0, 0));
    send_command(make_cmd(FUNC_RECT, 10, 12, 14, 17, COLOR_CLEAR, 1, 0, 0));
    send_command(make_cmd(FUNC_RECT, 16, 20, 12, 10, COLOR_CLEAR, 1, 1, 0));
    send_command(make_cmd(FUNC_RECT, 8, 30, 8, 30, COLOR_CLEAR, 0, 1, 0));
    send_command(make_cmd(FUNC_RECT, 68, 38, 255, 36, COLOR_CLEAR, 1, 1, 0));
    send_command(make_cmd(FUNC_RECT, 255, 255, 250, 254, COLOR_CLEAR, 0, 0, 0));
    send_command(make_cmd(FUNC_READ, 0, 0, 0, 0, COLOR_CLEAR, 0, 0, 2));
    send_command(make_cmd(FUNC_READ, 0, 0, 0, 0, COLOR_CLEAR, 0, 0, 4 * PANEL_WIDTH + 70));
    send_command(make_cmd(FUNC_READ, 0, 0, 0, 0, COLOR_CLEAR, 0, 0, STORE_BYTES));
    send_command(make_cmd(FUNC_READ, 0, 0, 0, 0, COLOR_CLEAR, 0, 0, 511));
    send_command(make_cmd(FUNC_FILL, 0, 0, 0, 0, COLOR_TOGGLE, 0, 0, 0));
    send_command(make_cmd(FUNC_PLOT, 3, 9, 0, 0, COLOR_CLEAR, 0, 0, 0));
    send_command(make_cmd(FUNC_READ, 0, 0, 0, 0, COLOR_CLEAR, 0, 0, 3 + PANEL_WIDTH));
    send_command(make_cmd(FUNC_FILL, 0, 0, 0, 0, COLOR_CLEAR, 0, 0, 0));

    // Random phases, one rotation each; rotation changes only when drained
    for (int p = 0; p < 6; p++) begin
      wait_for_results();
      if (p < 4) rot = rot_order[p];
      else rot = 2'($urandom_range(0, 3));
      write_rotation(rot);
      if (p == 5) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the result side for a long stretch so the engine backs up
        if (p == 1 && i == 20) hold_request = 1'b1;
        // Pause the sender until everything owed has come back
        if (p == 2 && i == PHASE_ITEMS / 2) wait_for_results();
        send_command(random_command());
      end
    end

    wait_for_results();
    repeat (16) @(posedge clk_i);

    $display("covered %0d plot, %0d rectangle, %0d fill and %0d read commands",
             sb.cmd_count[FUNC_PLOT], sb.cmd_count[FUNC_RECT],
             sb.cmd_count[FUNC_FILL], sb.cmd_count[FUNC_READ]);
    $display("rotations used %b, %0d results checked, %0d errors",
             sb.rotations_seen, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
